// ===== src/cmf_pkg.sv =====
`timescale 1ns / 1ps

package cmf_pkg;

  // Bus layout: eight motor slots in two drive groups of four.
  localparam int unsigned MOTOR_SLOTS = 8;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned GROUPS      = 2;
  localparam int unsigned GROUP_LANES = 4;

  // Default depth of the queue of pending frame bundles.
  localparam int unsigned BUNDLE_DEPTH_DEF = 4;

  // Scaling datapath widths.
  localparam int unsigned VALUE_W = 26;
  localparam int unsigned MAG_W   = 26;
  localparam int unsigned GAIN_W  = 23;
  localparam int unsigned PROD_W  = MAG_W + GAIN_W;
  localparam int unsigned RSUM_W  = PROD_W + 1;
  localparam int unsigned RND_W   = RSUM_W - 32;
  localparam int unsigned LIMIT_W = 14;
  localparam int unsigned SP_W    = 16;

  // Incoming command codes.
  typedef enum logic [2:0] {
    CMD_IDLE     = 3'd0,
    CMD_POSITION = 3'd1,
    CMD_VELOCITY = 3'd2,
    CMD_CURRENT  = 3'd3,
    CMD_MIT      = 3'd4,
    CMD_VOLTAGE  = 3'd5
  } cmd_e;

  // Drive mode codes as the motor controller knows them.
  typedef enum logic [2:0] {
    HW_VOLTAGE  = 3'd0,
    HW_MIT      = 3'd1,
    HW_CURRENT  = 3'd2,
    HW_VELOCITY = 3'd3,
    HW_POSITION = 3'd4
  } hw_mode_e;

  // Frame identifiers.
  localparam logic [10:0] ID_STATE    = 11'h038;
  localparam logic [10:0] ID_PARAM    = 11'h036;
  localparam logic [10:0] ID_REPORT   = 11'h034;
  localparam logic [10:0] ID_DRIVE_LO = 11'h032;
  localparam logic [10:0] ID_DRIVE_HI = 11'h033;

  // Gains in Q16 and setpoint limits per mode.
  localparam logic [GAIN_W-1:0]  GAIN_POSITION  = 23'd1043038;
  localparam logic [GAIN_W-1:0]  GAIN_VELOCITY  = 23'd6258227;
  localparam logic [GAIN_W-1:0]  GAIN_HUNDRED   = 23'd6553600;
  localparam logic [LIMIT_W-1:0] LIMIT_POSITION = 14'd5000;
  localparam logic [LIMIT_W-1:0] LIMIT_VELOCITY = 14'd16000;
  localparam logic [LIMIT_W-1:0] LIMIT_CURRENT  = 14'd7500;
  localparam logic [LIMIT_W-1:0] LIMIT_VOLTAGE  = 14'd4800;

  // Frame kinds of one command, in the order they go out.
  localparam int unsigned KIND_DISABLE = 0;
  localparam int unsigned KIND_PARAM   = 1;
  localparam int unsigned KIND_REPORT  = 2;
  localparam int unsigned KIND_ENABLE  = 3;
  localparam int unsigned KIND_DRIVE   = 4;
  localparam int unsigned NUM_KINDS    = 5;

  // A scaled command leaving the arithmetic pipeline.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        cmd;
    logic [SP_W-1:0]   sp;
  } scaled_t;

  // Everything needed to build the frames of one command.
  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    hw_mode_e             mode;
    logic                 report_on;
    logic [NUM_KINDS-1:0] kinds;
    logic                 group;
    logic [63:0]          drive_word;
  } bundle_t;

  function automatic logic [GAIN_W-1:0] gain_of(input logic [2:0] cmd);
    case (cmd)
      CMD_VELOCITY: gain_of = GAIN_VELOCITY;
      CMD_CURRENT:  gain_of = GAIN_HUNDRED;
      CMD_VOLTAGE:  gain_of = GAIN_HUNDRED;
      CMD_MIT:      gain_of = '0;
      default:      gain_of = GAIN_POSITION;
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] limit_of(input logic [2:0] cmd);
    case (cmd)
      CMD_VELOCITY: limit_of = LIMIT_VELOCITY;
      CMD_CURRENT:  limit_of = LIMIT_CURRENT;
      CMD_VOLTAGE:  limit_of = LIMIT_VOLTAGE;
      CMD_MIT:      limit_of = '0;
      default:      limit_of = LIMIT_POSITION;
    endcase
  endfunction

  function automatic hw_mode_e hw_of(input logic [2:0] cmd);
    case (cmd)
      CMD_VELOCITY: hw_of = HW_VELOCITY;
      CMD_CURRENT:  hw_of = HW_CURRENT;
      CMD_MIT:      hw_of = HW_MIT;
      CMD_VOLTAGE:  hw_of = HW_VOLTAGE;
      default:      hw_of = HW_POSITION;
    endcase
  endfunction

endpackage

// ===== src/can_motor_command_framer_top.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake               | Content
// ---------+-----------+-------------------------+----------------------------------------
// command  | in        | in_valid_i / in_stall_o | motor_i, command_mode_i, command_value_i
// frame    | out       | out_valid_o/out_stall_i | can_id_o, payload_o, last_o
// config   | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (present-motor mask)
//
// A command is taken in every cycle while the bundle queue has room.
// Its frames pass through three arithmetic stages, then the queue and the
// current-bundle register, and go out one per cycle: zero to five per command.
// The output port, one frame per cycle, sets the sustained rate.
// Reset sets all control state at once, motors enabled; no clearing pass is needed.
// A stalled output holds its frame; a full queue stalls the command channel.

module can_motor_command_framer_top import cmf_pkg::*; #(
  parameter int unsigned BUNDLE_DEPTH = BUNDLE_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [SLOT_W-1:0]         motor_i,
  input  logic [2:0]                command_mode_i,
  input  logic signed [VALUE_W-1:0] command_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [10:0]               can_id_o,
  output logic [63:0]               payload_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [7:0]                cfg_data_i
);

  logic    adv;
  logic    full;
  logic    push;
  scaled_t scaled;
  bundle_t bundle;

  // The whole pipeline moves together while the queue can take a bundle.
  assign adv         = !full;
  assign in_stall_o  = full;
  assign cfg_ready_o = 1'b1;

  cmf_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_valid_i      (in_valid_i),
    .motor_i         (motor_i),
    .command_mode_i  (command_mode_i),
    .command_value_i (command_value_i),
    .scaled_o        (scaled)
  );

  cmf_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .scaled_i   (scaled),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  cmf_emit #(
    .BUNDLE_DEPTH (BUNDLE_DEPTH)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .bundle_i    (bundle),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .can_id_o    (can_id_o),
    .payload_o   (payload_o),
    .last_o      (last_o)
  );

endmodule

// ===== src/cmf_scale.sv =====
`timescale 1ns / 1ps

module cmf_scale import cmf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      in_valid_i,
  input  logic [SLOT_W-1:0]         motor_i,
  input  logic [2:0]                command_mode_i,
  input  logic signed [VALUE_W-1:0] command_value_i,
  output scaled_t                   scaled_o
);

  // Stage one: take the magnitude and sign of the raw value.
  logic              s1_valid_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic [2:0]        s1_cmd_q;
  logic              s1_neg_q;
  logic [MAG_W-1:0]  s1_mag_q;
  logic              s1_neg_d;
  logic [MAG_W-1:0]  s1_mag_d;

  always_comb begin
    s1_neg_d = command_value_i[VALUE_W-1];
    s1_mag_d = s1_neg_d ? (~$unsigned(command_value_i) + MAG_W'(1))
                        : $unsigned(command_value_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_slot_q <= motor_i;
      s1_cmd_q  <= command_mode_i;
      s1_neg_q  <= s1_neg_d;
      s1_mag_q  <= s1_mag_d;
    end
  end

  // Stage two: multiply the magnitude by the gain of the mode.
  logic              s2_valid_q;
  logic [SLOT_W-1:0] s2_slot_q;
  logic [2:0]        s2_cmd_q;
  logic              s2_neg_q;
  logic [PROD_W-1:0] s2_prod_q;
  logic [PROD_W-1:0] s2_prod_d;

  assign s2_prod_d = PROD_W'(s1_mag_q) * PROD_W'(gain_of(s1_cmd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_slot_q <= s1_slot_q;
      s2_cmd_q  <= s1_cmd_q;
      s2_neg_q  <= s1_neg_q;
      s2_prod_q <= s2_prod_d;
    end
  end

  // Stage three: round half away from zero, clamp, then restore the sign.
  logic              s3_valid_q;
  logic [SLOT_W-1:0] s3_slot_q;
  logic [2:0]        s3_cmd_q;
  logic [SP_W-1:0]   s3_sp_q;
  logic [RSUM_W-1:0] rsum;
  logic [RND_W-1:0]  rounded;
  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] clamped;
  logic [SP_W-1:0]   s3_sp_d;

  always_comb begin
    rsum    = RSUM_W'(s2_prod_q) + (RSUM_W'(1) << 31);
    rounded = rsum[RSUM_W-1:32];
    limit   = limit_of(s2_cmd_q);
    clamped = (rounded > RND_W'(limit)) ? limit : rounded[LIMIT_W-1:0];
    s3_sp_d = s2_neg_q ? (SP_W'(0) - SP_W'(clamped)) : SP_W'(clamped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_slot_q <= s2_slot_q;
      s3_cmd_q  <= s2_cmd_q;
      s3_sp_q   <= s3_sp_d;
    end
  end

  assign scaled_o = '{valid: s3_valid_q, slot: s3_slot_q, cmd: s3_cmd_q, sp: s3_sp_q};

endmodule

// ===== src/cmf_track.sv =====
`timescale 1ns / 1ps

module cmf_track import cmf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  scaled_t    scaled_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  // Per-motor state, setpoint rows per group and the present-motor mask.
  hw_mode_e                  mode_q [MOTOR_SLOTS];
  hw_mode_e                  mode_d [MOTOR_SLOTS];
  logic [MOTOR_SLOTS-1:0]    en_q;
  logic [MOTOR_SLOTS-1:0]    en_d;
  logic [63:0]               row_q [GROUPS];
  logic [63:0]               row_d [GROUPS];
  logic [MOTOR_SLOTS-1:0]    upd_q;
  logic [MOTOR_SLOTS-1:0]    upd_d;
  logic [MOTOR_SLOTS-1:0]    cfg_q;

  logic                      grp;
  logic [1:0]                lane;
  hw_mode_e                  old_mode;
  hw_mode_e                  new_mode;
  logic                      idle;
  logic                      changed;
  logic [63:0]               row_new;
  logic [MOTOR_SLOTS-1:0]    mask_set;
  logic [MOTOR_SLOTS-1:0]    gmask;
  logic [MOTOR_SLOTS-1:0]    target;
  logic                      drive;
  logic [NUM_KINDS-1:0]      kinds;
  logic                      take;

  // Decide which frames this command causes.
  always_comb begin
    grp      = scaled_i.slot[SLOT_W-1];
    lane     = scaled_i.slot[1:0];
    old_mode = mode_q[scaled_i.slot];
    new_mode = hw_of(scaled_i.cmd);
    idle     = (scaled_i.cmd == CMD_IDLE);
    changed  = (new_mode != old_mode);

    row_new = row_q[grp];
    for (int i = 0; i < GROUP_LANES; i++) begin
      if (2'(i) == lane) begin
        row_new[SP_W*(GROUP_LANES-1-i) +: SP_W] = scaled_i.sp;
      end
    end

    mask_set = upd_q | (MOTOR_SLOTS'(1) << scaled_i.slot);
    gmask    = grp ? 8'hF0 : 8'h0F;
    target   = cfg_q & gmask;
    drive    = (target != '0) && ((mask_set & gmask) == target);

    kinds = '0;
    if (idle) begin
      kinds[KIND_DISABLE] = en_q[scaled_i.slot];
    end else begin
      kinds[KIND_DISABLE] = changed;
      kinds[KIND_PARAM]   = changed;
      kinds[KIND_REPORT]  = changed && (new_mode == HW_VOLTAGE || old_mode == HW_VOLTAGE);
      kinds[KIND_ENABLE]  = changed || !en_q[scaled_i.slot];
      kinds[KIND_DRIVE]   = drive;
    end

    take   = adv_i && scaled_i.valid;
    push_o = take && (kinds != '0);

    bundle_o.slot       = scaled_i.slot;
    bundle_o.mode       = new_mode;
    bundle_o.report_on  = (new_mode == HW_VOLTAGE);
    bundle_o.kinds      = kinds;
    bundle_o.group      = grp;
    bundle_o.drive_word = row_new;
  end

  // Next state of the per-motor records.
  always_comb begin
    mode_d = mode_q;
    en_d   = en_q;
    row_d  = row_q;
    upd_d  = upd_q;
    if (take) begin
      if (idle) begin
        en_d[scaled_i.slot] = 1'b0;
      end else begin
        mode_d[scaled_i.slot] = new_mode;
        en_d[scaled_i.slot]   = 1'b1;
        row_d[grp]            = row_new;
        upd_d                 = drive ? (mask_set & ~gmask) : mask_set;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        mode_q[i] <= HW_POSITION;
      end
      for (int g = 0; g < GROUPS; g++) begin
        row_q[g] <= '0;
      end
      en_q  <= '1;
      upd_q <= '0;
    end else begin
      mode_q <= mode_d;
      en_q   <= en_d;
      row_q  <= row_d;
      upd_q  <= upd_d;
    end
  end

  // Present-motor register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

endmodule

// ===== src/cmf_emit.sv =====
`timescale 1ns / 1ps

module cmf_emit import cmf_pkg::*; #(
  parameter int unsigned BUNDLE_DEPTH = BUNDLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  bundle_t     bundle_i,
  output logic        full_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] can_id_o,
  output logic [63:0] payload_o,
  output logic        last_o
);

  localparam int unsigned PTR_W = (BUNDLE_DEPTH > 1) ? $clog2(BUNDLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(BUNDLE_DEPTH + 1);

  localparam logic [7:0] STATE_DISABLE = 8'h01;
  localparam logic [7:0] STATE_ENABLE  = 8'h02;
  localparam logic [7:0] PARAM_MODE    = 8'h1C;
  localparam logic [7:0] REPORT_PERIOD = 8'd10;

  function automatic logic [63:0] state_word(input logic [SLOT_W-1:0] slot,
                                             input logic [7:0] code);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      if (SLOT_W'(i) == slot) begin
        w[8*(MOTOR_SLOTS-1-i) +: 8] = code;
      end
    end
    return w;
  endfunction

  // Bundle queue.
  bundle_t              mem_q [BUNDLE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     cnt_d;

  // Bundle being sent and the frame kinds it still owes.
  bundle_t              cur_q;
  logic [NUM_KINDS-1:0] kinds_q;
  logic [NUM_KINDS-1:0] pick;
  logic [NUM_KINDS-1:0] rest;
  logic                 fire;
  logic                 pop;
  logic [7:0]           bus_id;

  assign full_o = (cnt_q == CNT_W'(BUNDLE_DEPTH));

  // Frame sequencing: lowest owed kind goes first.
  always_comb begin
    pick        = kinds_q & (~kinds_q + NUM_KINDS'(1));
    rest        = kinds_q & ~pick;
    out_valid_o = (kinds_q != '0);
    last_o      = (rest == '0);
    fire        = out_valid_o && !out_stall_i;
    pop         = ((kinds_q == '0) || (fire && rest == '0)) && (cnt_q != '0);
    cnt_d       = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  // Frame contents.
  always_comb begin
    bus_id = 8'(cur_q.slot) + 8'd1;
    if (pick[KIND_DRIVE]) begin
      can_id_o  = cur_q.group ? ID_DRIVE_HI : ID_DRIVE_LO;
      payload_o = cur_q.drive_word;
    end else if (pick[KIND_PARAM]) begin
      can_id_o  = ID_PARAM;
      payload_o = {bus_id, PARAM_MODE, 5'b0, cur_q.mode, 40'b0};
    end else if (pick[KIND_REPORT]) begin
      can_id_o  = ID_REPORT;
      payload_o = {bus_id, 7'b0, cur_q.report_on, REPORT_PERIOD,
                   8'h01, 8'h03, 8'h0D, 8'h0A, 8'h00};
    end else if (pick[KIND_ENABLE]) begin
      can_id_o  = ID_STATE;
      payload_o = state_word(cur_q.slot, STATE_ENABLE);
    end else begin
      can_id_o  = ID_STATE;
      payload_o = state_word(cur_q.slot, STATE_DISABLE);
    end
  end

  // Pointers, fill count and the owed kinds; a new bundle is read when the
  // current one is finished or absent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      kinds_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(BUNDLE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(BUNDLE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
      if (pop) begin
        kinds_q <= mem_q[rd_ptr_q].kinds;
      end else if (fire) begin
        kinds_q <= rest;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
    if (pop) begin
      cur_q <= mem_q[rd_ptr_q];
    end
  end

endmodule

// ===== src/cmf_checker.sv =====
`timescale 1ns / 1ps

module cmf_checker import cmf_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [10:0] can_id_o,
  input logic [63:0] payload_o,
  input logic        last_o
);

  // A stalled frame holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(can_id_o)
      && $stable(payload_o) && $stable(last_o))
    else $error("stalled frame changed");

  // A drive frame always closes its command.
  a_drive_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (can_id_o == ID_DRIVE_LO || can_id_o == ID_DRIVE_HI) |-> last_o)
    else $error("drive frame not marked last");

  // Parameter and report frames are never the last of their command; an enable always follows them.
  a_mid_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (can_id_o == ID_PARAM || can_id_o == ID_REPORT) |-> !last_o)
    else $error("mode change sequence ended early");

  // After a mode-set transaction, a report or the enable comes straight away.
  a_param_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && can_id_o == ID_PARAM
      |=> out_valid_o && (can_id_o == ID_REPORT || can_id_o == ID_STATE))
    else $error("mode-set not followed by report or enable");

endmodule

bind can_motor_command_framer_top cmf_checker u_checker (.*);
